>>> rtl/csu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package csu_pkg;

   localparam int PIN_COUNT    = 16;
   localparam int BYTE_W       = 8;
   localparam int PAYLOAD_BITS = 7;
   localparam int MAX_WORDS    = 7;
   localparam int ACC_W        = 22;
   localparam int CNT_W        = 5;
   localparam int RANK_W       = 4;
   localparam int WORDS_W      = 3;
   localparam int KIND_W       = 3;
   localparam int SAMPLE_W     = 16;

   localparam logic [SAMPLE_W-1:0] PIN_MASK = SAMPLE_W'((17'd1 << PIN_COUNT) - 17'd1);

   localparam logic [1:0] PHASE_DATA = 2'd0;
   localparam logic [1:0] PHASE_ZERO = 2'd1;
   localparam logic [1:0] PHASE_END  = 2'd2;

   localparam logic [BYTE_W-1:0] TOKEN_RESTART = 8'h00;
   localparam logic [BYTE_W-1:0] TOKEN_END     = 8'h01;

   typedef enum logic [KIND_W-1:0] {
      KIND_SAMPLE   = 3'd0,
      KIND_DONE     = 3'd1,
      KIND_PROBE    = 3'd2,
      KIND_ENCODE   = 3'd3,
      KIND_BOUNDARY = 3'd4,
      KIND_RESTART  = 3'd5
   } kind_type;

endpackage
`default_nettype wire

>>> rtl/csu_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface csu_req_if import csu_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] byte_in;

   modport source (output valid, output byte_in, input ready);
   modport sink   (input valid, input byte_in, output ready);
endinterface
`default_nettype wire

>>> rtl/csu_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface csu_rsp_if import csu_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [SAMPLE_W-1:0] sample;
   logic [BYTE_W-1:0]   probe_code;
   logic                last;

   modport source (output valid, output kind, output sample, output probe_code,
                   output last, input ready);
   modport sink   (input valid, input kind, input sample, input probe_code,
                   input last, output ready);
endinterface
`default_nettype wire

>>> rtl/capture_stream_unpacker.sv
// A byte is decoded the cycle after it is accepted; the decode state then passes it to the emit
// state (samples) or the final state (status word), which load the output register, later on stalls.
// A clean end passes through the emit state before its final status word; a committing data
// byte may yield no samples. A byte that is held or opens a token returns straight to idle.
// Ready is low while the sequencer works on a byte; the output register lets it run ahead.
// Reset (synchronous, active high) clears the stream state, the mask and the output valid.
`timescale 1ns / 1ps
`default_nettype none
module capture_stream_unpacker import csu_pkg::*; (
   input  wire              clock,
   input  wire              reset,
   csu_req_if.sink          req_if,
   csu_rsp_if.source        rsp_if,
   input  wire              csr_we,
   input  wire [SAMPLE_W-1:0] csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_DECODE = 4'b0010,
      S_EMIT   = 4'b0100,
      S_FINAL  = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [SAMPLE_W-1:0]  mask_ff, mask_in;
   logic [BYTE_W-1:0]    byte_ff, byte_in;
   logic [1:0]           phase_ff, phase_in;
   logic [PAYLOAD_BITS-1:0] held_ff [2];
   logic [PAYLOAD_BITS-1:0] held_in [2];
   logic [1:0]           hc_ff, hc_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [WORDS_W-1:0]   words_ff, words_in;
   logic                 final_ff, final_in;
   kind_type             pend_kind_ff, pend_kind_in;
   logic [BYTE_W-1:0]    pend_code_ff, pend_code_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   kind_type             rsp_kind_ff, rsp_kind_in;
   logic [SAMPLE_W-1:0]  rsp_sample_ff, rsp_sample_in;
   logic [BYTE_W-1:0]    rsp_code_ff, rsp_code_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [SAMPLE_W-1:0]  pin_mask;
   logic [CNT_W-1:0]     nb;
   logic [RANK_W-1:0]    rank [PIN_COUNT];
   logic [SAMPLE_W-1:0]  sample_word;
   logic                 out_free;
   logic                 have_word;
   logic                 more;
   logic [CNT_W-1:0]     cnt_left;
   logic [PAYLOAD_BITS-1:0] pad;
   logic                 commit_en;
   logic [PAYLOAD_BITS-1:0] commit_src;
   logic [2:0]           commit_n;
   logic [BYTE_W-1:0]    commit_lowmask;
   logic [ACC_W-1:0]     commit_bits;
   logic                 clear_en;

   assign pin_mask = mask_ff & PIN_MASK;
   assign nb       = CNT_W'($countones(pin_mask));
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // rank of each pin among the selected pins picks its bit of the word
   always_comb begin
      for (int p = 0; p < PIN_COUNT; p++) begin
         rank[p] = RANK_W'($countones(pin_mask & SAMPLE_W'((17'd1 << p) - 17'd1)));
      end
      sample_word = '0;
      for (int p = 0; p < PIN_COUNT; p++) begin
         sample_word[p] = pin_mask[p] & acc_ff[{1'b0, rank[p]}];
      end
   end

   assign have_word = (nb != '0) && (words_ff != WORDS_W'(MAX_WORDS)) && (cnt_ff >= nb);
   assign cnt_left  = cnt_ff - nb;
   assign more      = (words_ff + WORDS_W'(1) != WORDS_W'(MAX_WORDS)) && (cnt_left >= nb);
   assign pad       = (hc_ff == 2'd2) ? held_ff[1] : held_ff[0];

   assign commit_lowmask = (BYTE_W'(1) << commit_n) - BYTE_W'(1);
   assign commit_bits    = ACC_W'(commit_src & commit_lowmask[PAYLOAD_BITS-1:0]) << cnt_ff;

   always_comb begin
      state_in      = state_ff;
      mask_in       = mask_ff;
      byte_in       = byte_ff;
      phase_in      = phase_ff;
      held_in       = held_ff;
      hc_in         = hc_ff;
      acc_in        = acc_ff;
      cnt_in        = cnt_ff;
      words_in      = words_ff;
      final_in      = final_ff;
      pend_kind_in  = pend_kind_ff;
      pend_code_in  = pend_code_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_code_in   = rsp_code_ff;
      rsp_last_in   = rsp_last_ff;
      commit_en     = 1'b0;
      commit_src    = held_ff[0];
      commit_n      = 3'(PAYLOAD_BITS);
      clear_en      = 1'b0;

      if (csr_we) begin
         mask_in = csr_wdata;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               byte_in  = req_if.byte_in;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            words_in     = '0;
            pend_code_in = '0;
            case (phase_ff)
               PHASE_END: begin
                  if (byte_ff != '0) begin
                     pend_kind_in = KIND_PROBE;
                     pend_code_in = byte_ff;
                     clear_en     = 1'b1;
                     state_in     = S_FINAL;
                  end else if (nb == '0 || hc_ff == 2'd0 ||
                               pad > PAYLOAD_BITS'(PAYLOAD_BITS) ||
                               (hc_ff == 2'd1 && pad != '0)) begin
                     pend_kind_in = KIND_BOUNDARY;
                     clear_en     = 1'b1;
                     state_in     = S_FINAL;
                  end else begin
                     // trailer pad trims the byte before it
                     commit_en = (hc_ff == 2'd2);
                     commit_n  = 3'(PAYLOAD_BITS) - pad[2:0];
                     final_in  = 1'b1;
                     state_in  = S_EMIT;
                  end
               end
               PHASE_ZERO: begin
                  if (byte_ff == TOKEN_RESTART) begin
                     pend_kind_in = KIND_RESTART;
                     clear_en     = 1'b1;
                     state_in     = S_FINAL;
                  end else if (byte_ff == TOKEN_END) begin
                     phase_in = PHASE_END;
                     state_in = S_IDLE;
                  end else begin
                     pend_kind_in = KIND_ENCODE;
                     clear_en     = 1'b1;
                     state_in     = S_FINAL;
                  end
               end
               default: begin
                  if (byte_ff == '0) begin
                     phase_in = PHASE_ZERO;
                     state_in = S_IDLE;
                  end else if (!byte_ff[BYTE_W-1]) begin
                     pend_kind_in = KIND_ENCODE;
                     clear_en     = 1'b1;
                     state_in     = S_FINAL;
                  end else if (hc_ff == 2'd2) begin
                     // commit the older held byte, keep the last two back
                     commit_en  = 1'b1;
                     held_in[0] = held_ff[1];
                     held_in[1] = byte_ff[PAYLOAD_BITS-1:0];
                     final_in   = 1'b0;
                     state_in   = S_EMIT;
                  end else begin
                     held_in[hc_ff[0]] = byte_ff[PAYLOAD_BITS-1:0];
                     hc_in             = hc_ff + 2'd1;
                     state_in          = S_IDLE;
                  end
               end
            endcase
         end
         S_EMIT: begin
            if (have_word) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = KIND_SAMPLE;
                  rsp_sample_in = sample_word;
                  rsp_code_in   = '0;
                  rsp_last_in   = !final_ff && !more;
                  acc_in        = acc_ff >> nb;
                  cnt_in        = cnt_left;
                  words_in      = words_ff + WORDS_W'(1);
               end
            end else if (final_ff) begin
               pend_kind_in = (cnt_ff != '0) ? KIND_BOUNDARY : KIND_DONE;
               pend_code_in = '0;
               clear_en     = 1'b1;
               state_in     = S_FINAL;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_FINAL: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = pend_kind_ff;
               rsp_sample_in = '0;
               rsp_code_in   = pend_code_ff;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // committed bits are dropped while the mask is zero
      if (commit_en && nb != '0) begin
         acc_in = acc_ff | commit_bits;
         cnt_in = cnt_ff + CNT_W'(commit_n);
      end

      if (clear_en) begin
         phase_in = PHASE_DATA;
         hc_in    = '0;
         acc_in   = '0;
         cnt_in   = '0;
      end
   end

   assign req_if.ready      = (state_ff == S_IDLE);
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.kind       = rsp_kind_ff;
   assign rsp_if.sample     = rsp_sample_ff;
   assign rsp_if.probe_code = rsp_code_ff;
   assign rsp_if.last       = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mask_ff      <= '0;
         phase_ff     <= PHASE_DATA;
         hc_ff        <= '0;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         words_ff     <= '0;
         final_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mask_ff      <= mask_in;
         phase_ff     <= phase_in;
         hc_ff        <= hc_in;
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         words_ff     <= words_in;
         final_ff     <= final_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff       <= byte_in;
      held_ff       <= held_in;
      pend_kind_ff  <= pend_kind_in;
      pend_code_ff  <= pend_code_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule
`default_nettype wire

>>> rtl/csu_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module csu_checker import csu_pkg::*; (
   input wire                clock,
   input wire                reset,
   input wire                req_valid,
   input wire                req_ready,
   input wire                rsp_valid,
   input wire                rsp_ready,
   input wire [KIND_W-1:0]   rsp_kind,
   input wire [SAMPLE_W-1:0] rsp_sample,
   input wire [BYTE_W-1:0]   rsp_probe_code,
   input wire                rsp_last
);

   // a byte keeps the sequencer busy for at least the decode cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready high right after a byte was accepted");

   a_sample_only_on_sample: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_SAMPLE |-> rsp_sample == '0)
      else $error("nonzero sample on a status word");

   a_code_only_on_probe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_PROBE |-> rsp_probe_code == '0)
      else $error("nonzero probe code outside a probe error");

   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_SAMPLE |-> rsp_last)
      else $error("status word not marked last");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_sample))
      else $error("stalled result word changed");

endmodule

bind capture_stream_unpacker csu_checker u_csu_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_kind       (rsp_if.kind),
   .rsp_sample     (rsp_if.sample),
   .rsp_probe_code (rsp_if.probe_code),
   .rsp_last       (rsp_if.last)
);
`default_nettype wire
